>>> hdl/sasag_pkg.sv
// Shared types, constants and register codes for the strided stream address generator.
package sasag_pkg;

   localparam int NUM_PORTS       = 4;
   localparam int MAX_WIDTH_BYTES = 16;
   localparam int EMIT_PORTS      = (NUM_PORTS < 4) ? NUM_PORTS : 4;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_ADDR_WIDTH  = 5;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [27:0] ADDR_MASK  = 28'hfff_ffff;
   localparam logic [1:0]  STORE_BYTE_OFFSET = 2'd0;

   typedef enum logic [2:0] {
      REG_BASE_ADDRESS  = 3'd0,
      REG_INNER_STRIDE  = 3'd1,
      REG_INNER_LENGTH  = 3'd2,
      REG_MIDDLE_STRIDE = 3'd3,
      REG_MIDDLE_LENGTH = 3'd4,
      REG_OUTER_STRIDE  = 3'd5,
      REG_DIRECTION     = 3'd6
   } sasag_reg_type;

   localparam logic DIR_LOAD  = 1'b0;
   localparam logic DIR_STORE = 1'b1;

   typedef struct packed {
      logic [31:0] base_address;
      logic [31:0] inner_stride;
      logic [16:0] inner_length;
      logic [31:0] middle_stride;
      logic [16:0] middle_length;
      logic [31:0] outer_stride;
      logic        direction;
   } sasag_cfg_type;

   // One classified step waiting for the back end.
   typedef struct packed {
      logic [31:0] stream_address;
      logic [31:0] first_address;
      logic [15:0] addr_step;
      logic [1:0]  last_port;
      logic        is_null;
      logic        is_load;
   } sasag_entry_type;

endpackage

>>> hdl/sasag_csr.sv
// Configuration register file with APB-style write and read access.
module sasag_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sasag_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [sasag_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [sasag_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready,
   output sasag_pkg::sasag_cfg_type              cfg
);

   sasag_pkg::sasag_cfg_type cfg_ff;
   sasag_pkg::sasag_cfg_type cfg_in;
   sasag_pkg::sasag_reg_type reg_index;
   logic                     wr_en;

   assign reg_index  = sasag_pkg::sasag_reg_type'(csr_paddr[4:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            sasag_pkg::REG_BASE_ADDRESS:  cfg_in.base_address  = csr_pwdata;
            sasag_pkg::REG_INNER_STRIDE:  cfg_in.inner_stride  = csr_pwdata;
            sasag_pkg::REG_INNER_LENGTH:  cfg_in.inner_length  = csr_pwdata[16:0];
            sasag_pkg::REG_MIDDLE_STRIDE: cfg_in.middle_stride = csr_pwdata;
            sasag_pkg::REG_MIDDLE_LENGTH: cfg_in.middle_length = csr_pwdata[16:0];
            sasag_pkg::REG_OUTER_STRIDE:  cfg_in.outer_stride  = csr_pwdata;
            sasag_pkg::REG_DIRECTION:     cfg_in.direction     = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         sasag_pkg::REG_BASE_ADDRESS:  csr_prdata = cfg_ff.base_address;
         sasag_pkg::REG_INNER_STRIDE:  csr_prdata = cfg_ff.inner_stride;
         sasag_pkg::REG_INNER_LENGTH:  csr_prdata = {15'd0, cfg_ff.inner_length};
         sasag_pkg::REG_MIDDLE_STRIDE: csr_prdata = cfg_ff.middle_stride;
         sasag_pkg::REG_MIDDLE_LENGTH: csr_prdata = {15'd0, cfg_ff.middle_length};
         sasag_pkg::REG_OUTER_STRIDE:  csr_prdata = cfg_ff.outer_stride;
         sasag_pkg::REG_DIRECTION:     csr_prdata = {31'd0, cfg_ff.direction};
         default:                      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> hdl/sasag_front.sv
// Front end: loop counters, stream address and classification of each step.
module sasag_front (
   input  logic                        clock,
   input  logic                        reset,
   input  sasag_pkg::sasag_cfg_type    cfg,
   input  logic                        accept,
   input  logic [4:0]                  req_byte_count,
   input  logic [15:0]                 req_port_stride,
   input  logic                        req_write_enable,
   output sasag_pkg::sasag_entry_type  entry
);

   logic [31:0] inner_offset_ff,  inner_offset_in;
   logic [31:0] middle_offset_ff, middle_offset_in;
   logic [31:0] outer_offset_ff,  outer_offset_in;
   logic [15:0] inner_count_ff,   inner_count_in;
   logic [15:0] middle_count_ff,  middle_count_in;

   logic        one_d, two_d;
   logic        inner_go, middle_go;
   logic [31:0] middle_term, outer_term, stream_address;
   logic [6:0]  width_clamped, words, store_ports;
   logic        is_load, is_null;

   assign one_d = cfg.inner_length[16];
   assign two_d = cfg.middle_length[16];

   assign middle_term = one_d ? 32'd0 : middle_offset_ff;
   assign outer_term  = (one_d || two_d) ? 32'd0 : outer_offset_ff;
   assign stream_address = cfg.base_address + inner_offset_ff + middle_term + outer_term;

   assign inner_go  = one_d || (inner_count_ff < cfg.inner_length[15:0]);
   assign middle_go = two_d || (middle_count_ff < cfg.middle_length[15:0]);

   always_comb begin
      inner_offset_in  = inner_offset_ff;
      middle_offset_in = middle_offset_ff;
      outer_offset_in  = outer_offset_ff;
      inner_count_in   = inner_count_ff;
      middle_count_in  = middle_count_ff;
      if (accept) begin
         priority if (inner_go) begin
            inner_offset_in = inner_offset_ff + cfg.inner_stride;
            inner_count_in  = inner_count_ff + 16'd1;
         end else if (middle_go) begin
            inner_offset_in  = '0;
            middle_offset_in = middle_offset_ff + cfg.middle_stride;
            inner_count_in   = 16'd1;
            middle_count_in  = middle_count_ff + 16'd1;
         end else begin
            inner_offset_in  = '0;
            middle_offset_in = '0;
            outer_offset_in  = outer_offset_ff + cfg.outer_stride;
            inner_count_in   = 16'd1;
            middle_count_in  = 16'd1;
         end
      end
   end

   // Stores: one word per port while bytes remain.
   assign width_clamped = ({2'b00, req_byte_count} > 7'(sasag_pkg::MAX_WIDTH_BYTES))
                          ? 7'(sasag_pkg::MAX_WIDTH_BYTES) : {2'b00, req_byte_count};
   assign words       = (width_clamped + 7'd3) >> 2;
   assign store_ports = (words > 7'(sasag_pkg::EMIT_PORTS))
                        ? 7'(sasag_pkg::EMIT_PORTS) : words;

   assign is_load = (cfg.direction == sasag_pkg::DIR_LOAD);
   assign is_null = !is_load && (!req_write_enable || (words == 7'd0));

   always_comb begin
      entry.stream_address = stream_address;
      entry.is_load        = is_load;
      entry.is_null        = is_null;
      if (is_load) begin
         entry.first_address = {stream_address[31:2], 2'b00};
         entry.addr_step     = req_port_stride;
         entry.last_port     = 2'(sasag_pkg::EMIT_PORTS - 1);
      end else begin
         entry.first_address = stream_address;
         entry.addr_step     = 16'd4;
         entry.last_port     = is_null ? 2'd0 : 2'(store_ports - 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_offset_ff  <= '0;
         middle_offset_ff <= '0;
         outer_offset_ff  <= '0;
         inner_count_ff   <= 16'd1;
         middle_count_ff  <= 16'd1;
      end else begin
         inner_offset_ff  <= inner_offset_in;
         middle_offset_ff <= middle_offset_in;
         outer_offset_ff  <= outer_offset_in;
         inner_count_ff   <= inner_count_in;
         middle_count_ff  <= middle_count_in;
      end
   end

endmodule

>>> hdl/sasag_queue.sv
// Short FIFO of classified steps between the front and back ends.
module sasag_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sasag_pkg::sasag_entry_type  push_entry,
   output logic                        full,
   input  logic                        pop,
   output logic                        head_valid,
   output sasag_pkg::sasag_entry_type  head_entry
);

   localparam int PW = sasag_pkg::QUEUE_PTR_WIDTH;
   localparam int CW = sasag_pkg::QUEUE_CNT_WIDTH;

   sasag_pkg::sasag_entry_type slots_ff [sasag_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff,  count_in;

   assign full       = (count_ff == CW'(sasag_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(sasag_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(sasag_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   overflow_chk: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into a full step queue");

   underflow_chk: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("pop from an empty step queue");

   count_chk: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("step queue count did not follow a push");

endmodule

>>> hdl/sasag_back.sv
// Back end: fans each step out into per-port requests through an output register.
module sasag_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  sasag_pkg::sasag_entry_type  head_entry,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [31:0]                 rsp_stream_address,
   output logic [1:0]                  rsp_port_index,
   output logic [27:0]                 rsp_request_address,
   output logic                        rsp_request_valid,
   output logic [1:0]                  rsp_byte_offset,
   output logic                        rsp_last
);

   logic [1:0]  port_ff,  port_in;
   logic [31:0] acc_ff,   acc_in;
   logic [31:0] acc_cur;
   logic        emit, at_last;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_stream_address_ff;
   logic [1:0]  rsp_port_index_ff;
   logic [27:0] rsp_request_address_ff;
   logic        rsp_request_valid_ff;
   logic [1:0]  rsp_byte_offset_ff;
   logic        rsp_last_ff;

   assign emit    = head_valid && (!rsp_valid_ff || rsp_ready);
   assign at_last = (port_ff == head_entry.last_port);
   assign acc_cur = (port_ff == 2'd0) ? head_entry.first_address : acc_ff;
   assign pop     = emit && at_last;

   always_comb begin
      port_in      = port_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (at_last) begin
            port_in = 2'd0;
         end else begin
            port_in = port_ff + 2'd1;
            acc_in  = acc_cur + {16'd0, head_entry.addr_step};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_stream_address_ff  <= head_entry.stream_address;
         rsp_port_index_ff      <= port_ff;
         rsp_request_address_ff <= head_entry.is_null ? 28'd0
                                   : (acc_cur[27:0] & sasag_pkg::ADDR_MASK);
         rsp_request_valid_ff   <= !head_entry.is_null;
         rsp_byte_offset_ff     <= head_entry.is_load ? head_entry.stream_address[1:0]
                                   : sasag_pkg::STORE_BYTE_OFFSET;
         rsp_last_ff            <= at_last;
      end
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         port_ff      <= port_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stream_address  = rsp_stream_address_ff;
   assign rsp_port_index      = rsp_port_index_ff;
   assign rsp_request_address = rsp_request_address_ff;
   assign rsp_request_valid   = rsp_request_valid_ff;
   assign rsp_byte_offset     = rsp_byte_offset_ff;
   assign rsp_last            = rsp_last_ff;

   null_item_chk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_request_valid_ff |-> rsp_last_ff && rsp_port_index_ff == 2'd0)
      else $error("null result is not a lone port-0 last item");

   burst_chk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ready && !rsp_last_ff |=>
         rsp_valid_ff && rsp_port_index_ff == $past(rsp_port_index_ff) + 2'd1)
      else $error("results of one step did not follow back to back");

   port_reset_chk: assert property (@(posedge clock) disable iff (reset)
      pop |=> port_ff == 2'd0)
      else $error("port counter not cleared after a step finished");

endmodule

>>> hdl/strided_stream_address_generator_core.sv
// Top level of the strided stream address generator: CSRs, front end, step queue, back end.
// Each accepted item is one step of a three-level nested address loop; it yields one result
// per memory port (4 for a load, 1 to 4 for a store depending on the byte count) or a single
// null result for a store with nothing to write, delivered one result per cycle while
// rsp_ready is high. The front end updates the loop counters and classifies the step in the
// cycle it is accepted and pushes it into a 2-entry queue, so a new item is taken every cycle
// while the queue has room; the sustained rate is set by the single result port in the back
// end, issuing an item's results in turn. Results pass the step queue and output register.
// Configuration is to be written through the APB port only while idle, not enforced here.
module strided_stream_address_generator_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sasag_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [sasag_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [sasag_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                  csr_pready,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [4:0]                            req_byte_count,
   input  logic [15:0]                           req_port_stride,
   input  logic                                  req_write_enable,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [31:0]                           rsp_stream_address,
   output logic [1:0]                            rsp_port_index,
   output logic [27:0]                           rsp_request_address,
   output logic                                  rsp_request_valid,
   output logic [1:0]                            rsp_byte_offset,
   output logic                                  rsp_last
);

   sasag_pkg::sasag_cfg_type   cfg;
   sasag_pkg::sasag_entry_type push_entry;
   sasag_pkg::sasag_entry_type head_entry;
   logic                       accept, full, pop, head_valid;

   assign req_ready = !full;
   assign accept    = req_valid && !full;

   sasag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sasag_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .accept           (accept),
      .req_byte_count   (req_byte_count),
      .req_port_stride  (req_port_stride),
      .req_write_enable (req_write_enable),
      .entry            (push_entry)
   );

   sasag_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sasag_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_entry          (head_entry),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_stream_address  (rsp_stream_address),
      .rsp_port_index      (rsp_port_index),
      .rsp_request_address (rsp_request_address),
      .rsp_request_valid   (rsp_request_valid),
      .rsp_byte_offset     (rsp_byte_offset),
      .rsp_last            (rsp_last)
   );

endmodule
